@@ rtl/gfm_pkg.sv @@
// Shared opcodes, register indexes and field widths of the GF(2^m) multiply core.
package gfm_pkg;

    // Widths of the command and configuration fields.
    localparam int OPCODE_W    = 2;
    localparam int DEGREE_W    = 7;
    localparam int TAP_W       = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 7;

    // Operation codes carried by each command.
    localparam logic [OPCODE_W-1:0] OP_ADD = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_MUL = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SQR = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_RSV = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_DEGREE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_ONE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_TWO   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_THREE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PENTA     = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [DEGREE_W-1:0] RST_DEGREE    = 7'd64;
    localparam logic [TAP_W-1:0]    RST_TAP_ONE   = 6'd4;
    localparam logic [TAP_W-1:0]    RST_TAP_TWO   = 6'd3;
    localparam logic [TAP_W-1:0]    RST_TAP_THREE = 6'd1;

endpackage

@@ rtl/gf2m_field_multiply_core.sv @@
// GF(2^m) add, multiply and square unit with a pipelined shift-and-add multiplier.
// Each accepted command is registered at stage 0, then passes through the multiplier stages to the result strobe.
// Throughput: one command per cycle outside reset; each multiplier stage performs eight shift-and-add steps.
// busy is high only while reset is asserted; the result strobe lasts one cycle.
// Reset (synchronous, active low) empties the pipeline and restores the default pentanomial.
// The configuration port is always ready; write it only while no command is in flight.
module gf2m_field_multiply_core #(
    parameter int FIELD_BITS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Command channel
    input  logic                              start,
    output logic                              busy,
    input  logic [gfm_pkg::OPCODE_W-1:0]      i_opcode,
    input  logic [FIELD_BITS-1:0]             i_operand_a,
    input  logic [FIELD_BITS-1:0]             i_operand_b,
    // Result channel
    output logic                              o_strobe,
    output logic [FIELD_BITS-1:0]             o_field_result,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gfm_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [gfm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import gfm_pkg::*;

    localparam int STEPS      = 8;
    localparam int NUM_STAGES = (FIELD_BITS + STEPS - 1) / STEPS;
    localparam int LAT        = NUM_STAGES + 1;

    logic                  w_accept;
    logic                  w_cfg_write;

    logic [DEGREE_W-1:0]   r_field_degree;
    logic [TAP_W-1:0]      r_tap_one;
    logic [TAP_W-1:0]      r_tap_two;
    logic [TAP_W-1:0]      r_tap_three;
    logic                  r_pentanomial;

    logic [DEGREE_W-1:0]   w_degree;
    logic [FIELD_BITS-1:0] w_mask;
    logic [FIELD_BITS-1:0] w_poly;
    logic [FIELD_BITS-1:0] w_top_sel;

    logic [FIELD_BITS-1:0] n_a0;
    logic [FIELD_BITS-1:0] n_b0;
    logic [FIELD_BITS-1:0] n_acc0;

    logic                  r_valid [0:NUM_STAGES];
    logic [FIELD_BITS-1:0] r_acc   [0:NUM_STAGES];
    logic [FIELD_BITS-1:0] r_a     [0:NUM_STAGES-1];
    logic [FIELD_BITS-1:0] r_b     [0:NUM_STAGES-1];

    // Handshakes: the pipeline never stalls, so only reset holds commands off.
    assign busy        = ~i_rst_n;
    assign w_accept    = start & ~busy;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid & o_cfg_ready;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_degree <= RST_DEGREE;
            r_tap_one      <= RST_TAP_ONE;
            r_tap_two      <= RST_TAP_TWO;
            r_tap_three    <= RST_TAP_THREE;
            r_pentanomial  <= 1'b1;
        end else if (w_cfg_write) begin
            unique case (i_cfg_index)
                CFG_DEGREE:    r_field_degree <= i_cfg_data[DEGREE_W-1:0];
                CFG_TAP_ONE:   r_tap_one      <= i_cfg_data[TAP_W-1:0];
                CFG_TAP_TWO:   r_tap_two      <= i_cfg_data[TAP_W-1:0];
                CFG_TAP_THREE: r_tap_three    <= i_cfg_data[TAP_W-1:0];
                CFG_PENTA:     r_pentanomial  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective degree, clamped to the supported range.
    always_comb begin
        if (r_field_degree < DEGREE_W'(2)) begin
            w_degree = DEGREE_W'(2);
        end else if (r_field_degree > DEGREE_W'(FIELD_BITS)) begin
            w_degree = DEGREE_W'(FIELD_BITS);
        end else begin
            w_degree = r_field_degree;
        end
    end

    // Field mask, low part of the reduction polynomial and the top-bit select.
    // A tap at or above m is dropped; a tap of zero cancels the constant term.
    always_comb begin
        for (int i = 0; i < FIELD_BITS; i++) begin
            w_mask[i]    = DEGREE_W'(i) < w_degree;
            w_top_sel[i] = DEGREE_W'(i) == (w_degree - DEGREE_W'(1));
            w_poly[i]    = (i == 0)
                         ^ ({1'b0, r_tap_one} == DEGREE_W'(i))
                         ^ (r_pentanomial & ({1'b0, r_tap_two} == DEGREE_W'(i)))
                         ^ (r_pentanomial & ({1'b0, r_tap_three} == DEGREE_W'(i)));
            w_poly[i]    = w_poly[i] & w_mask[i];
        end
    end

    // Stage 0 setup: add and the reserved opcode are finished here, multiply and square enter the step chain.
    always_comb begin
        n_a0   = '0;
        n_b0   = '0;
        n_acc0 = '0;
        unique case (i_opcode)
            OP_ADD: begin
                n_acc0 = (i_operand_a ^ i_operand_b) & w_mask;
            end
            OP_MUL: begin
                n_a0 = i_operand_a & w_mask;
                n_b0 = i_operand_b & w_mask;
            end
            OP_SQR: begin
                n_a0 = i_operand_a & w_mask;
                n_b0 = i_operand_a & w_mask;
            end
            OP_RSV: begin
                n_acc0 = '0;
            end
            default: begin
                n_acc0 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a[0]   <= n_a0;
        r_b[0]   <= n_b0;
        r_acc[0] <= n_acc0;
    end

    // Multiplier stages: each handles eight bits of operand a.
    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        logic [FIELD_BITS-1:0] n_acc;
        logic [FIELD_BITS-1:0] n_b;

        // Accumulate the selected copy, then multiply b by x and reduce.
        always_comb begin
            n_acc = r_acc[s];
            n_b   = r_b[s];
            for (int j = 0; j < STEPS; j++) begin
                if (s * STEPS + j < FIELD_BITS) begin
                    if (r_a[s][s * STEPS + j]) begin
                        n_acc = n_acc ^ n_b;
                    end
                    if (|(n_b & w_top_sel)) begin
                        n_b = ((n_b << 1) & w_mask) ^ w_poly;
                    end else begin
                        n_b = (n_b << 1) & w_mask;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else begin
                r_valid[s+1] <= r_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_acc[s+1] <= n_acc;
        end

        if (s < NUM_STAGES - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                r_a[s+1] <= r_a[s];
                r_b[s+1] <= n_b;
            end
        end else begin : g_last
            // The final b value is not needed after the last step.
            logic w_unused_b;
            assign w_unused_b = ^n_b;
        end
    end

    assign o_strobe       = r_valid[NUM_STAGES];
    assign o_field_result = r_acc[NUM_STAGES];

`ifndef ASSERT_OFF
    // Every result strobe traces back to a command accepted at the pipeline input.
    a_strobe_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, LAT))
        else $error("result strobe without a matching accepted command");

    // The reserved opcode yields a zero result.
    a_reserved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_opcode == OP_RSV, LAT)) |-> (o_field_result == '0))
        else $error("reserved opcode produced a nonzero result");

    // Reset empties the pipeline.
    a_reset_flush: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_strobe)
        else $error("result strobe right after reset");

    // Add never feeds the multiplier chain: operand a enters stage 0 as zero.
    a_add_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_opcode == OP_ADD)) |=> (r_a[0] == '0))
        else $error("add command entered the multiplier chain");
`endif

endmodule

@@ tb/gf2m_field_multiply_core_test.sv @@
// Self-checking testbench for the GF(2^m) add, multiply and square core.
module gf2m_field_multiply_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import gfm_pkg::*;

    localparam int FIELD_BITS = 64;

    // One row of the directed stimulus table; known marks a typed-in result.
    typedef struct packed {
        logic [OPCODE_W-1:0]   op;
        logic [FIELD_BITS-1:0] a;
        logic [FIELD_BITS-1:0] b;
        logic                  known;
        logic [FIELD_BITS-1:0] result;
    } t_field_cmd;

    // Local copy of the field registers.
    typedef struct packed {
        logic [DEGREE_W-1:0] degree;
        logic [TAP_W-1:0]    tap_one;
        logic [TAP_W-1:0]    tap_two;
        logic [TAP_W-1:0]    tap_three;
        logic                penta;
    } t_field_cfg;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [OPCODE_W-1:0]     i_opcode;
    logic [FIELD_BITS-1:0]   i_operand_a;
    logic [FIELD_BITS-1:0]   i_operand_b;
    logic                    o_strobe;
    logic [FIELD_BITS-1:0]   o_field_result;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_INDEX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    t_field_cfg              field_cfg;
    logic [FIELD_BITS-1:0]   pending_results[$];
    t_field_cmd              directed_cmds[$];
    int                      mismatch_count = 0;
    bit                      back_to_back = 0;

    gf2m_field_multiply_core #(
        .FIELD_BITS(FIELD_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .o_strobe       (o_strobe),
        .o_field_result (o_field_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Mask of the bits below the effective degree.
    function automatic logic [FIELD_BITS-1:0] degree_mask(int m);
        return (m >= FIELD_BITS) ? '1 : ((64'd1 << m) - 64'd1);
    endfunction

    // A tap contributes its term only when it lies below the degree.
    function automatic logic [FIELD_BITS-1:0] tap_term(logic [TAP_W-1:0] t, int m);
        return (int'(t) < m) ? (64'd1 << t) : '0;
    endfunction

    // Expected field element for one command under the current registers.
    function automatic logic [FIELD_BITS-1:0] field_op_result(
        logic [OPCODE_W-1:0] op, logic [FIELD_BITS-1:0] a, logic [FIELD_BITS-1:0] b);
        int                    m;
        logic [FIELD_BITS-1:0] mask;
        logic [FIELD_BITS-1:0] poly;
        logic [FIELD_BITS-1:0] x;
        logic [FIELD_BITS-1:0] y;
        logic [FIELD_BITS-1:0] acc;
        logic                  top;
        m = int'(field_cfg.degree);
        if (m < 2) m = 2;
        if (m > FIELD_BITS) m = FIELD_BITS;
        mask = degree_mask(m);
        poly = 64'd1 ^ tap_term(field_cfg.tap_one, m);
        if (field_cfg.penta)
            poly = poly ^ tap_term(field_cfg.tap_two, m) ^ tap_term(field_cfg.tap_three, m);
        poly = poly & mask;
        x = a & mask;
        y = ((op == OP_SQR) ? a : b) & mask;
        acc = '0;
        case (op)
            OP_ADD: begin
                acc = x ^ y;
            end
            OP_MUL, OP_SQR: begin
                // Shift-and-add with reduction after every shift.
                for (int i = 0; i < m; i++) begin
                    if (x[i]) acc = acc ^ y;
                    top = y[m-1];
                    y = (y << 1) & mask;
                    if (top) y = y ^ poly;
                end
            end
            default: begin
                acc = '0;
            end
        endcase
        return acc & mask;
    endfunction

    // Idle cycles before the next command: mostly short, a few long.
    function automatic int pick_gap();
        int r;
        if (back_to_back) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Operand mix: extremes, single bits, values below 2^m and raw 64-bit words.
    function automatic logic [FIELD_BITS-1:0] pick_operand();
        int m;
        m = int'(field_cfg.degree);
        if (m < 2) m = 2;
        if (m > FIELD_BITS) m = FIELD_BITS;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, FIELD_BITS - 1);
            3: return degree_mask(m);
            4, 5: return {$urandom, $urandom} & degree_mask(m);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Send one command and record its expected result at acceptance.
    task automatic issue_command(t_field_cmd cmd);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start       = 1'b1;
        i_opcode    = cmd.op;
        i_operand_a = cmd.a;
        i_operand_b = cmd.b;
        do @(posedge i_clk); while (busy);
        if (cmd.known)
            pending_results.push_back(cmd.result);
        else
            pending_results.push_back(field_op_result(cmd.op, cmd.a, cmd.b));
        @(negedge i_clk);
    endtask

    // Wait at a falling edge until every outstanding transaction has returned.
    task automatic drain_pipeline();
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // One configuration write transaction; the local copy follows at acceptance.
    task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_DEGREE:    field_cfg.degree    = data[DEGREE_W-1:0];
            CFG_TAP_ONE:   field_cfg.tap_one   = data[TAP_W-1:0];
            CFG_TAP_TWO:   field_cfg.tap_two   = data[TAP_W-1:0];
            CFG_TAP_THREE: field_cfg.tap_three = data[TAP_W-1:0];
            CFG_PENTA:     field_cfg.penta     = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Program a whole reduction polynomial once the pipeline is empty.
    task automatic set_field(logic [CFG_DATA_W-1:0] degree, logic [CFG_DATA_W-1:0] k1,
                             logic [CFG_DATA_W-1:0] k2, logic [CFG_DATA_W-1:0] k3,
                             logic [CFG_DATA_W-1:0] penta);
        drain_pipeline();
        write_register(CFG_TAP_ONE, k1);
        write_register(CFG_TAP_TWO, k2);
        write_register(CFG_TAP_THREE, k3);
        write_register(CFG_PENTA, penta);
        write_register(CFG_DEGREE, degree);
        // Writes to unused indexes must leave the field alone.
        if ($urandom_range(0, 2) == 0)
            write_register(
                CFG_INDEX_W'($urandom_range(int'(CFG_PENTA) + 1, (1 << CFG_INDEX_W) - 1)),
                CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
    endtask

    // A batch of random commands, some batches fully back to back.
    task automatic run_random(int count);
        t_field_cmd cmd;
        int         r;
        back_to_back = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 15);
            if (r == 0)     cmd.op = OP_RSV;
            else if (r < 5) cmd.op = OP_ADD;
            else if (r < 11) cmd.op = OP_MUL;
            else            cmd.op = OP_SQR;
            cmd.a      = pick_operand();
            cmd.b      = pick_operand();
            cmd.known  = 1'b0;
            cmd.result = '0;
            issue_command(cmd);
        end
        back_to_back = 0;
    endtask

    // Result checker: every strobe must match the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_field_result);
                mismatch_count++;
            end else if (o_field_result !== pending_results[0]) begin
                $display("%0t: field_result mismatch, expected %h, actual %h",
                         $time, pending_results[0], o_field_result);
                mismatch_count++;
                void'(pending_results.pop_front());
            end else begin
                void'(pending_results.pop_front());
            end
        end
    end

    // Run limit well above the slowest correct run.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Stimulus sequence.
    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_opcode    = OP_ADD;
        i_operand_a = '0;
        i_operand_b = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DEGREE;
        i_cfg_data  = '0;
        field_cfg   = '{RST_DEGREE, RST_TAP_ONE, RST_TAP_TWO, RST_TAP_THREE, 1'b1};

        // Directed rows for the default field x^64 + x^4 + x^3 + x + 1.
        directed_cmds.push_back('{OP_ADD, 64'h0, 64'h0, 1'b1, 64'h0});
        directed_cmds.push_back('{OP_ADD, '1, 64'h0, 1'b1, '1});
        directed_cmds.push_back('{OP_ADD, '1, '1, 1'b1, 64'h0});
        directed_cmds.push_back('{OP_ADD, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                                  1'b1, '1});
        directed_cmds.push_back('{OP_MUL, 64'h0, '1, 1'b1, 64'h0});
        directed_cmds.push_back('{OP_MUL, '1, 64'h1, 1'b1, '1});
        directed_cmds.push_back('{OP_MUL, 64'h1, 64'h1234_5678_9ABC_DEF0, 1'b1,
                                  64'h1234_5678_9ABC_DEF0});
        directed_cmds.push_back('{OP_MUL, 64'h8000_0000_0000_0000, 64'h2, 1'b1, 64'h1B});
        directed_cmds.push_back('{OP_SQR, 64'h0, '1, 1'b1, 64'h0});
        directed_cmds.push_back('{OP_SQR, 64'h1, '1, 1'b1, 64'h1});
        directed_cmds.push_back('{OP_SQR, 64'h1_0000_0000, 64'h0, 1'b1, 64'h1B});
        directed_cmds.push_back('{OP_RSV, '1, '1, 1'b1, 64'h0});
        directed_cmds.push_back('{OP_RSV, 64'h0, 64'h0, 1'b1, 64'h0});
        directed_cmds.push_back('{OP_MUL, '1, '1, 1'b0, 64'h0});
        directed_cmds.push_back('{OP_MUL, 64'h8000_0000_0000_0000, '1, 1'b0, 64'h0});
        directed_cmds.push_back('{OP_MUL, 64'hDEAD_BEEF_0123_4567, 64'h0F1E_2D3C_4B5A_6978,
                                  1'b0, 64'h0});
        directed_cmds.push_back('{OP_SQR, '1, 64'h0, 1'b0, 64'h0});
        directed_cmds.push_back('{OP_SQR, 64'h8000_0000_0000_0000, 64'h0, 1'b0, 64'h0});
        directed_cmds.push_back('{OP_SQR, 64'hA5A5_A5A5_5A5A_5A5A, '1, 1'b0, 64'h0});
        directed_cmds.push_back('{OP_ADD, 64'hFFFF_0000_FFFF_0000, 64'h0F0F_0F0F_0F0F_0F0F,
                                  1'b0, 64'h0});

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed table right after reset, back to back.
        back_to_back = 1;
        foreach (directed_cmds[i]) issue_command(directed_cmds[i]);
        back_to_back = 0;
        run_random(20);

        // Directed fields: smallest, AES-sized, clamped degrees, tap zero, taps too high.
        set_field(7'd2, 7'd1, 7'd0, 7'd0, 7'd0);
        run_random(30);
        set_field(7'd8, 7'd4, 7'd3, 7'd1, 7'd1);
        run_random(30);
        set_field(7'd0, 7'd1, 7'd0, 7'd0, 7'd0);
        run_random(25);
        set_field(7'd1, 7'd1, 7'd1, 7'd1, 7'd1);
        run_random(25);
        set_field(7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F);
        run_random(30);
        set_field(7'd63, 7'd1, 7'd0, 7'd0, 7'd0);
        run_random(30);
        set_field(7'd7, 7'd0, 7'd5, 7'd2, 7'd0);
        run_random(25);
        set_field(7'd16, 7'd20, 7'd16, 7'd5, 7'd1);
        run_random(25);
        set_field(7'd64, 7'd0, 7'd0, 7'd0, 7'd1);
        run_random(25);
        set_field(7'd64, 7'd63, 7'd62, 7'd61, 7'd1);
        run_random(25);

        // Random fields, mostly in the legal degree range.
        for (int p = 0; p < 6; p++) begin
            set_field(($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                  : 7'($urandom_range(2, 64)),
                      7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                      7'($urandom_range(0, 127)), 7'($urandom_range(0, 1)));
            run_random(55);
        end
        start = 1'b0;

        // Let the pipeline empty, then watch for stray results.
        for (int n = 0; n < 200 && pending_results.size() != 0; n++) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: missing results, expected %0d more, actual 0",
                     $time, pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/gfm_pkg.sv
rtl/gf2m_field_multiply_core.sv
tb/gf2m_field_multiply_core_test.sv
